// ===== design/lsma_pkg.sv =====
package lsma_pkg;

	// Cache geometry
	localparam int NUM_WAYS = 8;
	localparam int NUM_SETS = 64;
	localparam int TAG_BITS = 32;

	localparam int WAY_W  = 3;
	localparam int SET_W  = 6;
	localparam int AGE_W  = 3;
	localparam int WIU_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK_MODE = 1'd1;

	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	// One way of the status row
	typedef struct packed {
		logic             dirty;
		logic [AGE_W-1:0] age;
		logic             valid;
	} way_status_t;

	localparam int ENTRY_W = $bits(way_status_t);
	localparam int ROW_W   = ENTRY_W * NUM_WAYS;

	typedef way_status_t [NUM_WAYS-1:0] status_row_t;

	// Saturating age increment
	function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
		age_up = (a >= AGE_MAX) ? AGE_MAX : a + AGE_W'(1);
	endfunction

endpackage

// ===== design/lsma_ram.sv =====
module lsma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/lru_set_miss_allocator_unit.sv =====
// LRU miss allocator: one miss request in, one allocation result out.
// Flow: an accepted request is registered while its set's status row is read,
// then the result is registered. No new request is taken until the
// read-modify-write of the set's status row in its status memory is done.
// Reset: control state and the 64 per-set row flags clear at once; a set whose
// flag is clear reads as all ways invalid, age 0, clean. No clearing pass.
module lru_set_miss_allocator_unit import lsma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// Miss requests
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // set_index[5:0], tag[37:6], is_write[38], zero pad
	// Allocation results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // way_used[2:0], evicted[3], write_back[4], zero pad
);

	logic [WIU_W-1:0]    ways_in_use_q;
	logic                write_back_mode_q;
	logic                busy_s1;
	logic [SET_W-1:0]    set_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic                wr_s1;
	logic [NUM_SETS-1:0] row_valid_q;
	logic                out_valid_q;
	logic [WAY_W-1:0]    way_q;
	logic                evicted_q;
	logic                wb_q;

	logic                accept;
	logic [SET_W-1:0]    in_set;
	logic [ROW_W-1:0]    rd_row;
	status_row_t         cur_row;
	status_row_t         new_row;
	logic [WAY_W:0]      n_ways;
	logic [WAY_W-1:0]    way_sel;
	logic                found_free;
	logic [AGE_W-1:0]    best_age;
	logic                wb_now;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_in_use_q     <= WIU_W'(NUM_WAYS);
			write_back_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAYS_IN_USE:     ways_in_use_q     <= cfg_wdata[WIU_W-1:0];
				REG_WRITE_BACK_MODE: write_back_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Take a request only when idle and the result slot will be free
	assign s_axis_tready = !busy_s1 && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_set        = s_axis_tdata[SET_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= in_set;
			tag_s1 <= s_axis_tdata[SET_W +: TAG_BITS];
			wr_s1  <= s_axis_tdata[SET_W+TAG_BITS];
		end
	end

	// Status rows: valid, age and dirty of every way of a set
	lsma_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_status_ram (
		.clk   (clk),
		.we    (busy_s1),
		.waddr (set_s1),
		.wdata (new_row),
		.re    (accept),
		.raddr (in_set),
		.rdata (rd_row)
	);

	// Tag store, one entry per set and way; written on allocation only
	lsma_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_SETS*NUM_WAYS)) u_tag_ram (
		.clk   (clk),
		.we    (busy_s1),
		.waddr ({set_s1, way_sel}),
		.wdata (tag_s1),
		.re    (1'b0),
		.raddr ({set_s1, way_sel}),
		.rdata ()
	);

	// Mark rows once written; an unwritten row reads as reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (busy_s1) begin
			row_valid_q[set_s1] <= 1'b1;
		end
	end

	assign cur_row = row_valid_q[set_s1] ? status_row_t'(rd_row) : status_row_t'('0);

	// Clamp the ways in use to 1..NUM_WAYS
	always_comb begin
		if (ways_in_use_q == '0) begin
			n_ways = (WAY_W+1)'(1);
		end else if (ways_in_use_q > WIU_W'(NUM_WAYS)) begin
			n_ways = (WAY_W+1)'(NUM_WAYS);
		end else begin
			n_ways = (WAY_W+1)'(ways_in_use_q);
		end
	end

	// Pick the lowest free way, else the oldest way (lowest wins a tie)
	always_comb begin
		logic [WAY_W-1:0] free_way;
		logic [WAY_W-1:0] old_way;
		free_way   = '0;
		old_way    = '0;
		found_free = 1'b0;
		best_age   = cur_row[0].age;
		for (int i = NUM_WAYS-1; i >= 0; i--) begin
			if ((WAY_W+1)'(i) < n_ways && !cur_row[i].valid) begin
				free_way   = WAY_W'(i);
				found_free = 1'b1;
			end
		end
		for (int i = 1; i < NUM_WAYS; i++) begin
			if ((WAY_W+1)'(i) < n_ways && cur_row[i].age > best_age) begin
				best_age = cur_row[i].age;
				old_way  = WAY_W'(i);
			end
		end
		way_sel = found_free ? free_way : old_way;
	end

	// Age the other ways and install the new line
	always_comb begin
		new_row = cur_row;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if ((WAY_W+1)'(i) < n_ways) begin
				if (found_free) begin
					if (cur_row[i].valid && WAY_W'(i) != way_sel) begin
						new_row[i].age = age_up(cur_row[i].age);
					end
				end else if (cur_row[i].age < best_age) begin
					new_row[i].age = age_up(cur_row[i].age);
				end
			end
		end
		new_row[way_sel].valid = 1'b1;
		new_row[way_sel].age   = '0;
		new_row[way_sel].dirty = write_back_mode_q ? wr_s1 : 1'b0;
	end

	assign wb_now = !found_free && write_back_mode_q && cur_row[way_sel].dirty;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			way_q     <= way_sel;
			evicted_q <= !found_free;
			wb_q      <= wb_now;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W-WAY_W-2)'(0), wb_q, evicted_q, way_q};

endmodule

// ===== dv/lru_set_miss_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module lru_set_miss_allocator_unit_tb;
	import lsma_pkg::*;

	// One allocation result as it should appear on the output stream
	typedef struct {
		logic [WAY_W-1:0] way_used;
		logic             evicted;
		logic             write_back;
	} alloc_t;

	// Mirror of the per-set status rows; predicts the allocation for each miss
	class miss_alloc_scoreboard;
		bit               line_valid [NUM_SETS][NUM_WAYS];
		bit [AGE_W-1:0]   line_age   [NUM_SETS][NUM_WAYS];
		bit               line_dirty [NUM_SETS][NUM_WAYS];
		logic [WIU_W-1:0] ways_cfg = 4'd8;
		logic             wb_cfg   = 1'b1;
		alloc_t           alloc_expected [$];
		int               errors   = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_WAYS_IN_USE: begin
					ways_cfg = val;
				end
				REG_WRITE_BACK_MODE: begin
					wb_cfg = val[0];
				end
				default: ;
			endcase
		endfunction

		// Saturating age step
		function bit [AGE_W-1:0] aged(bit [AGE_W-1:0] a);
			return (a == '1) ? a : a + 1'b1;
		endfunction

		// Allocate a way for an accepted miss request and queue the expected result
		function void note_miss(logic [SET_W-1:0] set_idx, logic is_write);
			int             n;
			int             i;
			int             way;
			bit             free_found;
			bit [AGE_W-1:0] oldest;
			alloc_t         res;
			// clamp the way count into 1..NUM_WAYS
			if (ways_cfg == 0)
				n = 1;
			else if (ways_cfg > NUM_WAYS)
				n = NUM_WAYS;
			else
				n = int'(ways_cfg);
			way        = 0;
			free_found = 1'b0;
			for (i = 0; i < n; i++) begin
				if (!free_found && !line_valid[set_idx][i]) begin
					way        = i;
					free_found = 1'b1;
				end
			end
			res.evicted    = !free_found;
			res.write_back = 1'b0;
			if (free_found) begin
				// age every other valid way in use
				for (i = 0; i < n; i++) begin
					if (line_valid[set_idx][i] && i != way)
						line_age[set_idx][i] = aged(line_age[set_idx][i]);
				end
			end else begin
				// evict the oldest way, lowest index on a tie
				oldest = line_age[set_idx][0];
				for (i = 1; i < n; i++) begin
					if (line_age[set_idx][i] > oldest) begin
						oldest = line_age[set_idx][i];
						way    = i;
					end
				end
				for (i = 0; i < n; i++) begin
					if (line_age[set_idx][i] < oldest)
						line_age[set_idx][i] = aged(line_age[set_idx][i]);
				end
				res.write_back = wb_cfg && line_dirty[set_idx][way];
			end
			line_valid[set_idx][way] = 1'b1;
			line_age[set_idx][way]   = '0;
			line_dirty[set_idx][way] = wb_cfg ? is_write : 1'b0;
			res.way_used = way[WAY_W-1:0];
			alloc_expected.push_back(res);
		endfunction

		// Compare an accepted result with the oldest expectation
		function void check_alloc(logic [OUT_DATA_W-1:0] tdata);
			alloc_t exp_r;
			if (alloc_expected.size() == 0) begin
				$error("allocation result 0x%02h with no miss request outstanding", tdata);
				errors++;
				return;
			end
			exp_r = alloc_expected.pop_front();
			if (tdata[2:0] !== exp_r.way_used) begin
				$error("way_used: expected %0d, got %0d", exp_r.way_used, tdata[2:0]);
				errors++;
			end
			if (tdata[3] !== exp_r.evicted) begin
				$error("evicted: expected %0d, got %0d", exp_r.evicted, tdata[3]);
				errors++;
			end
			if (tdata[4] !== exp_r.write_back) begin
				$error("write_back: expected %0d, got %0d", exp_r.write_back, tdata[4]);
				errors++;
			end
		endfunction
	endclass

	// Way counts for the random phases, extremes and out-of-range values included
	localparam logic [WIU_W-1:0] WAYS_PLAN [12] = '{
		4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2, 4'd5, 4'd7, 4'd6, 4'd4, 4'd8
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // set_index[5:0], tag[37:6], is_write[38], zero pad
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // way_used[2:0], evicted[3], write_back[4], zero pad

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	miss_alloc_scoreboard sb;

	lru_set_miss_allocator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Stall the result stream at random
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_alloc(m_axis_tdata);
	end

	// Offer one miss request, with an optional idle gap ahead of it
	task automatic send_miss(logic [SET_W-1:0] set_idx, logic [TAG_BITS-1:0] tag,
			logic is_write);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 2);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {1'b0, is_write, tag, set_idx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_miss(set_idx, is_write);
	endtask

	// Hold off requests until every expected result has arrived
	task automatic drain;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.alloc_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	initial begin
		int                    phase;
		int                    k;
		int                    pause_at;
		logic [SET_W-1:0]      hot;
		logic [SET_W-1:0]      set_idx;
		logic [CFG_DATA_W-1:0] wb_word;
		sb = new;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill set 0 at the reset settings, alternating read and write misses
		send_miss(6'd0, 32'h0000_0000, 1'b0);
		send_miss(6'd0, 32'hFFFF_FFFF, 1'b1);
		send_miss(6'd0, 32'hAAAA_AAAA, 1'b0);
		send_miss(6'd0, 32'h5555_5555, 1'b1);
		for (k = 4; k < NUM_WAYS; k++)
			send_miss(6'd0, $urandom, k[0]);
		// evict a clean line, then a dirty one
		send_miss(6'd0, 32'h1234_5678, 1'b1);
		send_miss(6'd0, 32'h8765_4321, 1'b0);
		send_miss(6'd63, 32'hFFFF_FFFF, 1'b1);
		drain;

		// Write-through over two ways: dirty bits clear, no write-backs
		write_reg(REG_WAYS_IN_USE, 4'd2);
		write_reg(REG_WRITE_BACK_MODE, 4'b0000);
		repeat (3) send_miss(6'd0, $urandom, 1'b1);
		drain;

		// A way count of zero acts as one; only bit 0 of the mode counts
		write_reg(REG_WAYS_IN_USE, 4'd0);
		write_reg(REG_WRITE_BACK_MODE, 4'b1111);
		send_miss(6'd5, $urandom, 1'b1);
		send_miss(6'd5, $urandom, 1'b1);
		drain;

		// An oversized way count acts as the full set; ages left uneven above
		write_reg(REG_WAYS_IN_USE, 4'd15);
		send_miss(6'd0, $urandom, 1'b0);
		send_miss(6'd0, $urandom, 1'b1);
		send_miss(6'd5, $urandom, 1'b0);
		drain;

		// Random misses, mostly to a few hot sets so that they fill and evict
		for (phase = 0; phase < 12; phase++) begin
			write_reg(REG_WAYS_IN_USE, WAYS_PLAN[phase]);
			wb_word    = CFG_DATA_W'($urandom);
			wb_word[0] = (phase % 3 != 1);
			write_reg(REG_WRITE_BACK_MODE, wb_word);
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 50;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 50;
				end
				default: begin
					send_idle_pct  = 36;
					recv_stall_pct = 36;
				end
			endcase
			hot      = SET_W'($urandom);
			pause_at = $urandom_range(10, 80);
			for (k = 0; k < 92; k++) begin
				if (k == pause_at)
					drain;
				if ($urandom_range(0, 9) < 7)
					set_idx = hot + SET_W'($urandom_range(0, 3));
				else
					set_idx = SET_W'($urandom);
				send_miss(set_idx, $urandom, 1'($urandom_range(0, 1)));
			end
			drain;
		end

		if (sb.errors == 0) begin
			$display("lru_set_miss_allocator_unit verification clean");
		end else begin
			$display("lru_set_miss_allocator_unit verification failed");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("lru_set_miss_allocator_unit verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lsma_pkg.sv
design/lsma_ram.sv
design/lru_set_miss_allocator_unit.sv
dv/lru_set_miss_allocator_unit_tb.sv
